// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled away for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define PCLC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define PCLC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PCLC_ASSERT(label, clk, rst_n, prop, msg)

`define PCLC_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== design/pclc_pkg.sv =====
// ----------------------------------------------------------------------------
// pclc_pkg
// shared types and constants of the pump command lockout controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pclc_pkg;

  localparam int unsigned TIMER_BITS_DEF = 16;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned RSP_W      = 3;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LIMIT_W-1:0] START_LIMIT_RST = 8'd5;
  localparam logic [MS_W-1:0]    PULSE_MS_RST    = 16'd1000;
  localparam logic [MS_W-1:0]    COOLDOWN_MS_RST = 16'd30000;
  localparam logic [MS_W-1:0]    MSG_GAP_MS_RST  = 16'd1000;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_CMD    = 2'd1,
    REQ_UNLOCK = 2'd2
  } req_type_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_STATUS  = 2'd0,
    CMD_ON      = 2'd1,
    CMD_OFF     = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  typedef enum logic [RSP_W-1:0] {
    RSP_NONE   = 3'd0,
    RSP_ON     = 3'd1,
    RSP_OFF    = 3'd2,
    RSP_LOCKED = 3'd3,
    RSP_WAIT   = 3'd4
  } rsp_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LIMIT = 2'd0,
    CFG_PULSE_MS    = 2'd1,
    CFG_COOLDOWN_MS = 2'd2,
    CFG_MSG_GAP_MS  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] start_limit;
    logic [MS_W-1:0]    pulse_ms;
    logic [MS_W-1:0]    cooldown_ms;
    logic [MS_W-1:0]    message_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CMD_W-1:0] command_code;
  } item_t;

  typedef struct packed {
    rsp_code_e response_code;
    logic      on_drive;
    logic      off_drive;
    logic      running_flag;
    logic      locked_flag;
  } result_t;

endpackage

// ===== design/pclc_req_if.sv =====
// ----------------------------------------------------------------------------
// pclc_req_if
// request channel: tick, command or unlock words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pclc_req_if
  import pclc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [CMD_W-1:0] command_code;

  modport source (output valid, output req_type, output command_code, input ready);
  modport sink   (input valid, input req_type, input command_code, output ready);
endinterface

// ===== design/pclc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pclc_rsp_if
// result channel: response code and output levels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pclc_rsp_if
  import pclc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [RSP_W-1:0] response_code;
  logic             on_drive;
  logic             off_drive;
  logic             running_flag;
  logic             locked_flag;

  modport source (output valid, output response_code, output on_drive, output off_drive,
                  output running_flag, output locked_flag, input ready);
  modport sink   (input valid, input response_code, input on_drive, input off_drive,
                  input running_flag, input locked_flag, output ready);
endinterface

// ===== design/pclc_cfg.sv =====
// ----------------------------------------------------------------------------
// pclc_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pclc_cfg
  import pclc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_START_LIMIT: cfg_d.start_limit    = wdata_i[LIMIT_W-1:0];
        CFG_PULSE_MS:    cfg_d.pulse_ms       = wdata_i[MS_W-1:0];
        CFG_COOLDOWN_MS: cfg_d.cooldown_ms    = wdata_i[MS_W-1:0];
        CFG_MSG_GAP_MS:  cfg_d.message_gap_ms = wdata_i[MS_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_limit    <= START_LIMIT_RST;
      cfg_q.pulse_ms       <= PULSE_MS_RST;
      cfg_q.cooldown_ms    <= COOLDOWN_MS_RST;
      cfg_q.message_gap_ms <= MSG_GAP_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/pclc_core.sv =====
// ----------------------------------------------------------------------------
// pclc_core
// controller state and the registered update for one word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pclc_core
  import pclc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  // compare width covering both timers and register values
  localparam int unsigned CW = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;

  logic                  pend_vld_q, pend_vld_d;
  cmd_e                  pend_cmd_q, pend_cmd_d;
  logic [LIMIT_W-1:0]    start_cnt_q, start_cnt_d;
  logic                  lock_q, lock_d;
  logic                  running_q, running_d;
  logic [TIMER_BITS-1:0] since_act_q, since_act_d;
  logic [TIMER_BITS-1:0] since_msg_q, since_msg_d;
  logic                  pulse_q, pulse_d;
  logic                  on_q, on_d;
  logic                  off_q, off_d;

  logic [TIMER_BITS-1:0] act_inc, msg_inc;
  logic                  at_limit;
  logic                  skip_pulse;
  rsp_code_e             rsp;

  assign act_inc  = (&since_act_q) ? since_act_q : since_act_q + TIMER_BITS'(1);
  assign msg_inc  = (&since_msg_q) ? since_msg_q : since_msg_q + TIMER_BITS'(1);
  assign at_limit = (start_cnt_q >= cfg_i.start_limit);

  always_comb begin
    pend_vld_d  = pend_vld_q;
    pend_cmd_d  = pend_cmd_q;
    start_cnt_d = start_cnt_q;
    lock_d      = lock_q;
    running_d   = running_q;
    since_act_d = since_act_q;
    since_msg_d = since_msg_q;
    pulse_d     = pulse_q;
    on_d        = on_q;
    off_d       = off_q;
    skip_pulse  = 1'b0;
    rsp         = RSP_NONE;

    case (req_type_e'(item_i.req_type))
      REQ_TICK: begin
        since_act_d = act_inc;
        since_msg_d = msg_inc;
        if (pend_vld_q && (CW'(msg_inc) > CW'(cfg_i.message_gap_ms))) begin
          pend_vld_d = 1'b0;
          if (pend_cmd_q == CMD_STATUS) begin
            // status does not restart the message gap
            skip_pulse = 1'b1;
            if (lock_q || at_limit) begin
              rsp = RSP_LOCKED;
            end else begin
              rsp = running_q ? RSP_ON : RSP_OFF;
            end
          end else begin
            since_msg_d = '0;
            if (CW'(act_inc) < CW'(cfg_i.cooldown_ms)) begin
              skip_pulse = 1'b1;
              rsp        = RSP_WAIT;
            end else begin
              case (pend_cmd_q)
                CMD_ON: begin
                  if (at_limit) begin
                    lock_d     = 1'b1;
                    skip_pulse = 1'b1;
                    rsp        = RSP_LOCKED;
                  end else begin
                    on_d        = 1'b1;
                    running_d   = 1'b1;
                    start_cnt_d = (&start_cnt_q) ? start_cnt_q
                                                 : start_cnt_q + LIMIT_W'(1);
                    pulse_d     = 1'b1;
                    since_act_d = '0;
                    rsp         = RSP_ON;
                  end
                end
                CMD_OFF: begin
                  off_d       = 1'b1;
                  running_d   = 1'b0;
                  pulse_d     = 1'b1;
                  since_act_d = '0;
                  rsp         = RSP_OFF;
                end
                default: rsp = RSP_NONE;
              endcase
            end
          end
        end
        // drive pulse ends once its time has run out
        if (!skip_pulse && pulse_d && (CW'(since_act_d) > CW'(cfg_i.pulse_ms))) begin
          on_d    = 1'b0;
          off_d   = 1'b0;
          pulse_d = 1'b0;
        end
      end
      REQ_CMD: begin
        pend_cmd_d = cmd_e'(item_i.command_code);
        pend_vld_d = 1'b1;
      end
      REQ_UNLOCK: begin
        start_cnt_d = '0;
        lock_d      = 1'b0;
      end
      default: rsp = RSP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q  <= 1'b0;
      pend_cmd_q  <= CMD_STATUS;
      start_cnt_q <= '0;
      lock_q      <= 1'b0;
      running_q   <= 1'b0;
      since_act_q <= '0;
      since_msg_q <= '0;
      pulse_q     <= 1'b0;
      on_q        <= 1'b0;
      off_q       <= 1'b0;
    end else if (step_i) begin
      pend_vld_q  <= pend_vld_d;
      pend_cmd_q  <= pend_cmd_d;
      start_cnt_q <= start_cnt_d;
      lock_q      <= lock_d;
      running_q   <= running_d;
      since_act_q <= since_act_d;
      since_msg_q <= since_msg_d;
      pulse_q     <= pulse_d;
      on_q        <= on_d;
      off_q       <= off_d;
    end
  end

  assign result_o.response_code = rsp;
  assign result_o.on_drive      = on_d;
  assign result_o.off_drive     = off_d;
  assign result_o.running_flag  = running_d;
  assign result_o.locked_flag   = lock_d;

endmodule

// ===== design/pump_command_lockout_controller.sv =====
// ----------------------------------------------------------------------------
// pump_command_lockout_controller
// remote motor command controller with start-count lockout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one word per clock on the request channel: a 1 ms tick, a decoded
// command or an unlock press. Each word yields exactly one result word: it
// is first held in the input register, then the controller state and the
// result register update together when it steps. Sustained rate is one
// word per cycle while the result side is not stalled; a stalled result
// stops the pipe and back-pressure reaches the request side only once the
// input register is also full. Commands wait as pending until a tick finds
// the message gap elapsed. No memories, no init sweep.
module pump_command_lockout_controller
  import pclc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pclc_req_if.sink              req_if,
  pclc_rsp_if.source            rsp_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld_q, in_vld_d;
  logic    out_vld_q, out_vld_d;
  result_t rsp_q, result;
  logic    advance;
  logic    in_take;
  logic    step;

  // register file
  pclc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // pipe moves when the result register is empty or being drained
  assign advance      = !out_vld_q || rsp_if.ready;
  assign req_if.ready = !in_vld_q || advance;
  assign in_take      = req_if.valid && req_if.ready;
  assign step         = in_vld_q && advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = advance ? in_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.req_type     <= req_if.req_type;
      in_q.command_code <= req_if.command_code;
    end
    if (step) begin
      rsp_q <= result;
    end
  end

  // controller state and next-result logic
  pclc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign rsp_if.valid         = out_vld_q;
  assign rsp_if.response_code = rsp_q.response_code;
  assign rsp_if.on_drive      = rsp_q.on_drive;
  assign rsp_if.off_drive     = rsp_q.off_drive;
  assign rsp_if.running_flag  = rsp_q.running_flag;
  assign rsp_if.locked_flag   = rsp_q.locked_flag;

  // a held word in the input register is never overwritten
  `PCLC_ASSERT(a_in_hold, clk_i, rst_ni, (in_vld_q && !advance) |=> (in_vld_q && $stable(in_q)), "input word lost while stalled")

  // only ticks produce a response code
  `PCLC_ASSERT(a_nontick_none, clk_i, rst_ni, (step && (in_q.req_type != REQ_TICK)) |=> (rsp_q.response_code == RSP_NONE), "response on a non-tick word")

  // unlock always clears the lockout in its own result
  `PCLC_ASSERT(a_unlock_clears, clk_i, rst_ni, (step && (in_q.req_type == REQ_UNLOCK)) |=> !rsp_q.locked_flag, "lock survives unlock")

endmodule
